// File: rtl/core/utf8_to_utf16_transcoder_defines.svh
// assertion macros used by the transcoder top level
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UTT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transcoder check failed: same-cycle implication");

// next-cycle implication
`define UTT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transcoder check failed: next-cycle implication");

// condition that must never hold
`define UTT_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("transcoder check failed: forbidden condition");

`endif

// File: rtl/core/utt_pkg.sv
// types and constants of the utf-8 to utf-16 transcoder
package utt_pkg;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_BAD   = 3'd1,
        ST_TRUNC = 3'd2,
        ST_BIG   = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [15:0] CAP_RESET    = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_string;
        logic       last_of_string;
    } utf8_beat_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_present;
        logic        string_done;
        logic [2:0]  finish_status;
        logic [15:0] units_written;
    } result_t;

    // results caused by one byte, res0 first
    typedef struct packed {
        logic [1:0] n;
        result_t    res0;
        result_t    res1;
    } step_t;

    typedef struct packed {
        logic [1:0] count;
        logic       room;
    } obuf_stat_t;

endpackage

// File: rtl/core/utt_chan_if.sv
// valid/ready channel with a typed payload
interface utt_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/utt_decode.sv
// decode state and per-byte result generation
module utt_decode
    import utt_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  utf8_beat_t      beat,
    input  logic [15:0]     capacity,
    output step_t           step
);

    localparam int LIM_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [LIM_W-1:0] COUNT_MAX = LIM_W'({COUNT_BITS{1'b1}});

    logic [20:0]           pc_reg, pc_next, pc_cur;
    logic [1:0]            be_reg, be_next, be_cur;
    logic [COUNT_BITS-1:0] uc_reg, uc_next, uc_cur;
    logic                  st_reg, st_next, st_cur;
    status_t               ss_reg, ss_next, ss_cur;

    logic [LIM_W-1:0] cap_ext, limit, uc_ext;
    logic             full_now, pair_full, complete;
    logic [7:0]       b;
    logic [19:0]      v;
    logic [1:0]       nu;
    logic [15:0]      u0, u1;
    status_t          done_status;

    assign b       = beat.data_byte;
    assign cap_ext = LIM_W'(capacity);
    assign limit   = (cap_ext < COUNT_MAX) ? cap_ext : COUNT_MAX;

    always_comb
    begin
        // a first byte clears running state before it is judged
        pc_cur = beat.first_of_string ? '0 : pc_reg;
        be_cur = beat.first_of_string ? '0 : be_reg;
        uc_cur = beat.first_of_string ? '0 : uc_reg;
        st_cur = beat.first_of_string ? 1'b0 : st_reg;
        ss_cur = beat.first_of_string ? ST_OK : ss_reg;

        uc_ext    = LIM_W'(uc_cur);
        full_now  = uc_ext >= limit;
        pair_full = ({1'b0, uc_ext} + (LIM_W+1)'(1)) >= {1'b0, limit};

        pc_next  = pc_cur;
        be_next  = be_cur;
        st_next  = st_cur;
        ss_next  = ss_cur;
        complete = 1'b0;
        nu       = 2'd0;
        u0       = '0;
        u1       = '0;

        if (!st_cur)
        begin
            if (be_cur == 2'd0)
            begin
                if (full_now)
                begin
                    st_next = 1'b1;
                    ss_next = ST_FULL;
                end
                else if (!b[7])
                begin
                    pc_next  = 21'(b);
                    complete = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    pc_next = 21'(b[4:0]);
                    be_next = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    pc_next = 21'(b[3:0]);
                    be_next = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    pc_next = 21'(b[2:0]);
                    be_next = 2'd3;
                end
                else
                begin
                    st_next = 1'b1;
                    ss_next = ST_BAD;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                st_next = 1'b1;
                ss_next = ST_BAD;
                be_next = 2'd0;
            end
            else
            begin
                pc_next  = {pc_cur[14:0], b[5:0]};
                be_next  = be_cur - 2'd1;
                complete = (be_cur == 2'd1);
            end
        end

        v = pc_next[19:0] - 20'h10000;
        if (complete)
        begin
            if (pc_next[20:16] == 5'd0)
            begin
                nu = 2'd1;
                u0 = pc_next[15:0];
            end
            else if (pc_next[20:16] <= 5'h10)
            begin
                if (pair_full)
                begin
                    st_next = 1'b1;
                    ss_next = ST_FULL;
                end
                else
                begin
                    nu = 2'd2;
                    u0 = HI_SURR_BASE | 16'(v[19:10]);
                    u1 = LO_SURR_BASE | 16'(v[9:0]);
                end
            end
            else
            begin
                st_next = 1'b1;
                ss_next = ST_BIG;
            end
        end

        // sequence left open by the string's last byte
        if (beat.last_of_string && !st_next && be_next != 2'd0)
        begin
            st_next = 1'b1;
            ss_next = ST_TRUNC;
            be_next = 2'd0;
        end

        uc_next     = uc_cur + COUNT_BITS'(nu);
        done_status = st_next ? ss_next : ST_OK;

        step = '0;
        if (nu != 2'd0)
        begin
            step.n                  = nu;
            step.res0.code_unit     = u0;
            step.res0.unit_present  = 1'b1;
            step.res0.string_done   = beat.last_of_string && (nu == 2'd1);
            step.res0.finish_status = ST_OK;
            step.res0.units_written = 16'(uc_cur + COUNT_BITS'(1));
            if (nu == 2'd2)
            begin
                step.res1.code_unit     = u1;
                step.res1.unit_present  = 1'b1;
                step.res1.string_done   = beat.last_of_string;
                step.res1.finish_status = ST_OK;
                step.res1.units_written = 16'(uc_cur + COUNT_BITS'(2));
            end
        end
        else if (beat.last_of_string)
        begin
            step.n                  = 2'd1;
            step.res0.string_done   = 1'b1;
            step.res0.finish_status = done_status;
            step.res0.units_written = 16'(uc_cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            be_reg <= '0;
            uc_reg <= '0;
            st_reg <= 1'b0;
            ss_reg <= ST_OK;
        end
        else if (accept)
        begin
            pc_reg <= pc_next;
            be_reg <= be_next;
            uc_reg <= uc_next;
            st_reg <= st_next;
            ss_reg <= ss_next;
        end
    end

endmodule

// File: rtl/core/utt_obuf.sv
// two-slot result buffer in front of the utf-16 channel
module utt_obuf
    import utt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  step_t       step,
    utt_chan_if.source  dst,
    output obuf_stat_t  stat
);

    result_t    slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next, remain, n_in;
    logic       pop;

    assign pop         = dst.valid && dst.ready;
    assign dst.valid   = (count_reg != 2'd0);
    assign dst.payload = slot0_reg;
    assign stat.count  = count_reg;
    // room for a surrogate pair after this cycle's pop
    assign stat.room   = (count_reg == 2'd0) || ((count_reg == 2'd1) && dst.ready);

    always_comb
    begin
        remain = count_reg - {1'b0, pop};
        n_in   = push ? step.n : 2'd0;
        case (remain)
            2'd0:
            begin
                slot0_next = step.res0;
                slot1_next = step.res1;
            end
            2'd1:
            begin
                slot0_next = pop ? slot1_reg : slot0_reg;
                slot1_next = step.res0;
            end
            default:
            begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
        count_next = remain + n_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// File: rtl/core/utf8_to_utf16_transcoder.sv
// utf-8 to utf-16 transcoder top level
//
// usage
//   utf8 takes one byte per beat with first/last-of-string marks; utf16
//   returns results: a code unit, or a status-only beat on a string's end
//   cfg writes output_capacity (units per string) whenever the block is idle
// timing
//   one byte per cycle while utf8.ready is high; a byte's first result shows on
//   utf16 in the cycle after its beat; a surrogate pair is two utf16 beats, so
//   utf8.ready stays low till the result buffer drains to one beat with utf16 ready
//   bytes that finish no code point and are not last give no beat
// reset
//   clears the decode state and empties the result buffer; output_capacity
//   returns to 65535
// stalls
//   the buffer keeps up to two waiting beats; utf8.ready is high only when
//   two slots will be free, so no result is ever dropped
`include "utf8_to_utf16_transcoder_defines.svh"

module utf8_to_utf16_transcoder
    import utt_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    utt_chan_if.sink   cfg,
    utt_chan_if.sink   utf8,
    utt_chan_if.source utf16
);

    logic [15:0] cap_reg;
    logic        utf8_acc;
    step_t       step;
    obuf_stat_t  stat;
    logic [2:0]  fill_next;

    // capacity register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.payload;
        end
    end

    // a byte is taken only when the buffer can hold both beats of a pair
    assign utf8.ready = stat.room;
    assign utf8_acc   = utf8.valid && utf8.ready;

    utt_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (utf8_acc),
        .beat     (utf8.payload),
        .capacity (cap_reg),
        .step     (step)
    );

    utt_obuf u_obuf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (utf8_acc),
        .step  (step),
        .dst   (utf16),
        .stat  (stat)
    );

    // buffer fill after this cycle, for the overflow check
    assign fill_next = 3'(stat.count) - 3'(utf16.valid && utf16.ready) + 3'(step.n);

    `UTT_ASSERT_NEVER(a_buf_overflow, utf8_acc && (fill_next > 3'd2))
    `UTT_ASSERT_NEXT(a_result_follows, utf8_acc && (step.n != 2'd0), utf16.valid)
    `UTT_ASSERT_IMPL(a_status_only_done, utf16.valid && !utf16.payload.unit_present, utf16.payload.string_done)
    `UTT_ASSERT_IMPL(a_unit_status_ok, utf16.valid && utf16.payload.unit_present, utf16.payload.finish_status == ST_OK)

endmodule
